FILE: sv/osrr_pkg.sv
// osrr_pkg: shared types, codes and widths of the operand stack block
// no dependencies; used by every other file of the block except osrr_ram
package osrr_pkg;

    localparam int WORD_W          = 32;
    localparam int OPCODE_W        = 3;
    localparam int STEP_W          = 16;
    localparam int COUNT_W         = 7;
    localparam int STATUS_W        = 2;
    localparam int STACK_DEPTH_DEF = 64;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH    = 3'd0,
        OP_POP     = 3'd1,
        OP_SWAP    = 3'd2,
        OP_DUP     = 3'd3,
        OP_ROTATE  = 3'd4,
        OP_REVERSE = 3'd5
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_COUNT = 2'd3
    } t_status;

    // pointer pair setups
    typedef enum logic [2:0] {
        PTR_SWAP,
        PTR_REV,
        PTR_TOP,
        PTR_SEG0,
        PTR_SEG1,
        PTR_SEG2
    } t_ptr_sel;

    // memory write sources
    typedef enum logic [2:0] {
        WR_NONE,
        WR_LO,
        WR_HI,
        WR_PUSH,
        WR_DUP
    } t_wr_sel;

    typedef struct packed {
        logic     load;
        logic     div_start;
        logic     ptr_load;
        t_ptr_sel ptr_sel;
        logic     ptr_step;
        logic     rd_en;
        t_wr_sel  wr_sel;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     pop_cap;
        logic     st_set;
        t_status  st_val;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic                empty;
        logic                full;
        logic                lt2;
        logic                n_le1;
        logic                n_gt_cnt;
        logic                div_done;
        logic                rem_zero;
        logic                lo_lt_hi;
        logic                out_free;
    } t_sts;

endpackage

FILE: sv/osrr_if.sv
// osrr_in_if, osrr_out_if: request and result channels with valid/ready
// depends on osrr_pkg for field widths
interface osrr_in_if;
    logic                                valid;
    logic                                ready;
    logic [osrr_pkg::OPCODE_W-1:0]       opcode;
    logic signed [osrr_pkg::WORD_W-1:0]  push_value;
    logic [osrr_pkg::STEP_W-1:0]         rotate_step;
    logic [osrr_pkg::COUNT_W-1:0]        rotate_count;

    modport source (
        output valid, opcode, push_value, rotate_step, rotate_count,
        input  ready
    );
    modport sink (
        input  valid, opcode, push_value, rotate_step, rotate_count,
        output ready
    );
endinterface

interface osrr_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [osrr_pkg::WORD_W-1:0]  popped_value;
    logic [osrr_pkg::STATUS_W-1:0]       status;
    logic [osrr_pkg::COUNT_W-1:0]        depth_now;

    modport source (
        output valid, popped_value, status, depth_now,
        input  ready
    );
    modport sink (
        input  valid, popped_value, status, depth_now,
        output ready
    );
endinterface

FILE: sv/osrr_ram.sv
// osrr_ram: generic memory, one write port, two registered read ports
// no dependencies
module osrr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

FILE: sv/osrr_mod.sv
// osrr_mod: bit-serial remainder unit for rotate step modulo rotate count
// depends on osrr_pkg for widths
module osrr_mod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [osrr_pkg::STEP_W-1:0]   i_num,
    input  logic [osrr_pkg::COUNT_W-1:0]  i_den,
    output logic                          o_done,
    output logic [osrr_pkg::COUNT_W-1:0]  o_rem
);
    import osrr_pkg::*;

    localparam int IW = $clog2(STEP_W);

    logic               r_busy;
    logic               r_done;
    logic [IW-1:0]      r_idx;
    logic [STEP_W-1:0]  r_num;
    logic [COUNT_W-1:0] r_den;
    logic [COUNT_W-1:0] r_rem;
    logic [COUNT_W:0]   n_trial;
    logic [COUNT_W-1:0] n_rem;

    // shift in one dividend bit, subtract when it fits
    always_comb begin
        n_trial = {r_rem, r_num[STEP_W-1]};
        if (n_trial >= {1'b0, r_den}) begin
            n_rem = COUNT_W'(n_trial - {1'b0, r_den});
        end else begin
            n_rem = COUNT_W'(n_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= IW'(STEP_W - 1);
            end else if (r_busy) begin
                r_idx <= r_idx - 1'b1;
                if (r_idx == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[STEP_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: sv/osrr_ctrl.sv
// osrr_ctrl: sequencer of the operand stack, issues datapath commands
// depends on osrr_pkg for command and status structs and codes
module osrr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  osrr_pkg::t_sts i_sts,
    output osrr_pkg::t_cmd o_cmd
);
    import osrr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_CHK,
        S_RD,
        S_WLO,
        S_WHI,
        S_TOP_RD,
        S_POP_END,
        S_DUP_WR,
        S_DONE
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_seg;
    logic [1:0] n_seg;
    t_cmd       cmd;

    always_comb begin
        cmd     = '0;
        cmd.ptr_sel = PTR_SWAP;
        cmd.wr_sel  = WR_NONE;
        cmd.st_val  = ST_OK;
        n_state = r_state;
        n_seg   = r_seg;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                unique case (i_sts.op) inside
                    OP_PUSH: begin
                        if (i_sts.full) begin
                            cmd.st_set = 1'b1;
                            cmd.st_val = ST_OVER;
                        end else begin
                            cmd.wr_sel  = WR_PUSH;
                            cmd.cnt_inc = 1'b1;
                        end
                    end
                    OP_POP, OP_DUP: begin
                        if (i_sts.empty) begin
                            cmd.st_set = 1'b1;
                            cmd.st_val = ST_UNDER;
                        end else if (i_sts.full && i_sts.op == OP_DUP) begin
                            cmd.st_set = 1'b1;
                            cmd.st_val = ST_OVER;
                        end else begin
                            cmd.ptr_load = 1'b1;
                            cmd.ptr_sel  = PTR_TOP;
                            n_state      = S_TOP_RD;
                        end
                    end
                    OP_SWAP: begin
                        if (i_sts.lt2) begin
                            cmd.st_set = 1'b1;
                            cmd.st_val = ST_UNDER;
                        end else begin
                            cmd.ptr_load = 1'b1;
                            cmd.ptr_sel  = PTR_SWAP;
                            n_state      = S_CHK;
                        end
                    end
                    OP_ROTATE: begin
                        if (!i_sts.n_le1) begin
                            cmd.div_start = 1'b1;
                            n_state       = S_DIV;
                        end
                    end
                    OP_REVERSE: begin
                        if (!i_sts.lt2) begin
                            cmd.ptr_load = 1'b1;
                            cmd.ptr_sel  = PTR_REV;
                            n_state      = S_CHK;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    if (i_sts.rem_zero) begin
                        n_state = S_DONE;
                    end else if (i_sts.n_gt_cnt) begin
                        cmd.st_set = 1'b1;
                        cmd.st_val = ST_COUNT;
                        n_state    = S_DONE;
                    end else begin
                        cmd.ptr_load = 1'b1;
                        cmd.ptr_sel  = PTR_SEG0;
                        n_seg        = 2'd0;
                        n_state      = S_CHK;
                    end
                end
            end
            S_CHK: begin
                if (i_sts.lo_lt_hi) begin
                    n_state = S_RD;
                end else if (i_sts.op == OP_ROTATE && r_seg != 2'd2) begin
                    // next reversal of the three-pass rotate
                    cmd.ptr_load = 1'b1;
                    cmd.ptr_sel  = (r_seg == 2'd0) ? PTR_SEG1 : PTR_SEG2;
                    n_seg        = r_seg + 2'd1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RD: begin
                cmd.rd_en = 1'b1;
                n_state   = S_WLO;
            end
            S_WLO: begin
                cmd.wr_sel = WR_LO;
                n_state    = S_WHI;
            end
            S_WHI: begin
                cmd.wr_sel   = WR_HI;
                cmd.ptr_step = 1'b1;
                n_state      = S_CHK;
            end
            S_TOP_RD: begin
                cmd.rd_en = 1'b1;
                if (i_sts.op == OP_POP) begin
                    cmd.cnt_dec = 1'b1;
                    n_state     = S_POP_END;
                end else begin
                    n_state = S_DUP_WR;
                end
            end
            S_POP_END: begin
                cmd.pop_cap = 1'b1;
                n_state     = S_DONE;
            end
            S_DUP_WR: begin
                cmd.wr_sel  = WR_DUP;
                cmd.cnt_inc = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seg   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_seg   <= n_seg;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

endmodule

FILE: sv/osrr_dp.sv
// osrr_dp: stack datapath with entry memory, pointers, count and result register
// depends on osrr_pkg, osrr_ram and osrr_mod
module osrr_dp #(
    parameter int STACK_DEPTH = osrr_pkg::STACK_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  osrr_pkg::t_cmd                      i_cmd,
    output osrr_pkg::t_sts                      o_sts,
    input  logic [osrr_pkg::OPCODE_W-1:0]       i_opcode,
    input  logic signed [osrr_pkg::WORD_W-1:0]  i_push_value,
    input  logic [osrr_pkg::STEP_W-1:0]         i_rotate_step,
    input  logic [osrr_pkg::COUNT_W-1:0]        i_rotate_count,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [osrr_pkg::WORD_W-1:0]  o_popped_value,
    output logic [osrr_pkg::STATUS_W-1:0]       o_status,
    output logic [osrr_pkg::COUNT_W-1:0]        o_depth_now
);
    import osrr_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int SW = CW + COUNT_W + 1;

    logic [OPCODE_W-1:0] r_op;
    logic [WORD_W-1:0]   r_val;
    logic [STEP_W-1:0]   r_step;
    logic [COUNT_W-1:0]  r_n;
    logic [CW-1:0]       r_cnt;
    logic [AW-1:0]       r_lo;
    logic [AW-1:0]       r_hi;
    logic [WORD_W-1:0]   r_popped;
    t_status             r_status;
    logic                r_out_valid;
    logic [WORD_W-1:0]   r_out_popped;
    logic [STATUS_W-1:0] r_out_status;
    logic [COUNT_W-1:0]  r_out_depth;

    logic [SW-1:0]       cnt_x;
    logic [SW-1:0]       n_x;
    logic [SW-1:0]       d_x;
    logic [SW-1:0]       base_x;
    logic [SW-1:0]       lo_x;
    logic [SW-1:0]       hi_x;
    logic                div_done;
    logic [COUNT_W-1:0]  rem;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [WORD_W-1:0]   wdata;
    logic [WORD_W-1:0]   rdata_a;
    logic [WORD_W-1:0]   rdata_b;

    osrr_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_step),
        .i_den   (r_n),
        .o_done  (div_done),
        .o_rem   (rem)
    );

    osrr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_re      (i_cmd.rd_en),
        .i_raddr_a (r_lo),
        .i_raddr_b (r_hi),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // pointer pair for the selected reversal span, or for the top entry
    always_comb begin
        cnt_x  = SW'(r_cnt);
        n_x    = SW'(r_n);
        d_x    = SW'(rem);
        base_x = cnt_x - n_x;
        case (i_cmd.ptr_sel)
            PTR_SWAP: begin
                lo_x = cnt_x - SW'(2);
                hi_x = cnt_x - SW'(1);
            end
            PTR_REV: begin
                lo_x = '0;
                hi_x = cnt_x - SW'(1);
            end
            PTR_TOP: begin
                lo_x = cnt_x - SW'(1);
                hi_x = cnt_x - SW'(1);
            end
            PTR_SEG0: begin
                lo_x = base_x;
                hi_x = base_x + d_x - SW'(1);
            end
            PTR_SEG1: begin
                lo_x = base_x + d_x;
                hi_x = base_x + n_x - SW'(1);
            end
            PTR_SEG2: begin
                lo_x = base_x;
                hi_x = base_x + n_x - SW'(1);
            end
            default: begin
                lo_x = '0;
                hi_x = '0;
            end
        endcase
    end

    always_comb begin
        we    = 1'b1;
        waddr = r_lo;
        wdata = rdata_b;
        case (i_cmd.wr_sel)
            WR_LO: begin
                waddr = r_lo;
                wdata = rdata_b;
            end
            WR_HI: begin
                waddr = r_hi;
                wdata = rdata_a;
            end
            WR_PUSH: begin
                waddr = r_cnt[AW-1:0];
                wdata = r_val;
            end
            WR_DUP: begin
                waddr = r_cnt[AW-1:0];
                wdata = rdata_a;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_val    <= i_push_value;
            r_step   <= i_rotate_step;
            r_n      <= i_rotate_count;
            r_popped <= '0;
            r_status <= ST_OK;
        end
        if (i_cmd.st_set) begin
            r_status <= i_cmd.st_val;
        end
        if (i_cmd.pop_cap) begin
            r_popped <= rdata_a;
        end
        if (i_cmd.ptr_load) begin
            r_lo <= lo_x[AW-1:0];
            r_hi <= hi_x[AW-1:0];
        end else if (i_cmd.ptr_step) begin
            r_lo <= r_lo + 1'b1;
            r_hi <= r_hi - 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_popped <= r_popped;
            r_out_status <= r_status;
            r_out_depth  <= COUNT_W'(r_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_cmd.cnt_dec) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.op       = r_op;
        o_sts.empty    = (r_cnt == '0);
        o_sts.full     = (r_cnt >= CW'(STACK_DEPTH));
        o_sts.lt2      = (r_cnt < CW'(2));
        o_sts.n_le1    = (r_n <= COUNT_W'(1));
        o_sts.n_gt_cnt = (n_x > cnt_x);
        o_sts.div_done = div_done;
        o_sts.rem_zero = (rem == '0);
        o_sts.lo_lt_hi = (r_lo < r_hi);
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_popped_value = r_out_popped;
    assign o_status       = r_out_status;
    assign o_depth_now    = r_out_depth;

endmodule

FILE: sv/operand_stack_rotate_reverse.sv
// operand_stack_rotate_reverse: top level of the bounded operand stack
// depends on osrr_pkg, osrr_if, osrr_ctrl, osrr_dp (with osrr_ram, osrr_mod)
//
// Requests arrive on i_req (opcode, push_value, rotate_step, rotate_count) and
// each produces exactly one result on o_rsp (popped_value, status, depth_now).
// Both channels use valid/ready; a request is taken when both are high.
// One request is worked at a time; i_req.ready is high only while idle.
// Work per request, from acceptance until o_rsp.valid rises:
//   push, unused opcodes, rejected, trivial rotate: decode (push writes there)
//   pop, duplicate: a read of the top entry; swap: one exchange
//   reverse of C entries: floor(C/2) exchanges
//   rotate of N entries: the remainder unit, then three reversals
//   over the N entries through the memory, skipped when the step is a
//   multiple of N or N exceeds the depth
// The entry memory has two registered read ports and one write port; each
// exchange (read, low write, high write, check) sets the rotate/reverse rate.
// The result sits in an output register: a stalled receiver holds it there,
// and the block already takes the next request; that request's result waits
// until the register frees.
// Synchronous active-low reset empties the stack and drops any pending result;
// no memory clearing pass is needed, entries above the count are never read.
module operand_stack_rotate_reverse #(
    parameter int STACK_DEPTH = osrr_pkg::STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    osrr_in_if.sink     i_req,
    osrr_out_if.source  o_rsp
);
    import osrr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    osrr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    osrr_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_opcode       (i_req.opcode),
        .i_push_value   (i_req.push_value),
        .i_rotate_step  (i_req.rotate_step),
        .i_rotate_count (i_req.rotate_count),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_popped_value (o_rsp.popped_value),
        .o_status       (o_rsp.status),
        .o_depth_now    (o_rsp.depth_now)
    );

endmodule

FILE: dv/tb_top.sv
// tb_top: self-checking bench for the operand stack with rotate and reverse
// depends on osrr_pkg, osrr_if and the operand_stack_rotate_reverse rtl
// a stack predictor in a scoreboard class checks every result against its request
import osrr_pkg::*;

typedef struct {
    logic signed [WORD_W-1:0] popped;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       depth;
} stack_result_t;

class stack_scoreboard;
    logic signed [WORD_W-1:0] entries [STACK_DEPTH_DEF];
    int unsigned              depth = 0;
    stack_result_t            expected_results [$];
    int                       errors = 0;
    int                       checked = 0;
    int                       op_seen [8] = '{default: 0};
    int                       status_seen [4] = '{default: 0};

    task report(string msg);
        errors++;
        if (errors <= 40) begin
            $display("mismatch: %s", msg);
        end
    endtask

    // stack behavior for one accepted request
    function void note_request(logic [OPCODE_W-1:0] op, logic signed [WORD_W-1:0] val,
                               logic [STEP_W-1:0] step, logic [COUNT_W-1:0] cnt);
        stack_result_t            r;
        int unsigned              n;
        int unsigned              s;
        int unsigned              base;
        logic signed [WORD_W-1:0] moved [STACK_DEPTH_DEF];
        logic signed [WORD_W-1:0] t;
        r.popped = '0;
        r.status = ST_OK;
        n = cnt;
        case (op)
            OP_PUSH: begin
                if (depth >= STACK_DEPTH_DEF) begin
                    r.status = ST_OVER;
                end else begin
                    entries[depth] = val;
                    depth++;
                end
            end
            OP_POP: begin
                if (depth == 0) begin
                    r.status = ST_UNDER;
                end else begin
                    depth--;
                    r.popped = entries[depth];
                end
            end
            OP_SWAP: begin
                if (depth < 2) begin
                    r.status = ST_UNDER;
                end else begin
                    t = entries[depth-1];
                    entries[depth-1] = entries[depth-2];
                    entries[depth-2] = t;
                end
            end
            OP_DUP: begin
                if (depth == 0) begin
                    r.status = ST_UNDER;
                end else if (depth >= STACK_DEPTH_DEF) begin
                    r.status = ST_OVER;
                end else begin
                    entries[depth] = entries[depth-1];
                    depth++;
                end
            end
            OP_ROTATE: begin
                if (n > 1) begin
                    s = step % n;
                    if (s != 0) begin
                        if (n > depth) begin
                            r.status = ST_COUNT;
                        end else begin
                            // position p from the top sits at base + n - 1 - p
                            base = depth - n;
                            for (int p = 0; p < n; p++) begin
                                moved[p] = entries[base + n - 1 - ((p + n - s) % n)];
                            end
                            for (int p = 0; p < n; p++) begin
                                entries[base + n - 1 - p] = moved[p];
                            end
                        end
                    end
                end
            end
            OP_REVERSE: begin
                for (int i = 0; i < depth / 2; i++) begin
                    t = entries[i];
                    entries[i] = entries[depth-1-i];
                    entries[depth-1-i] = t;
                end
            end
            default: ;
        endcase
        r.depth = COUNT_W'(depth);
        op_seen[op]++;
        status_seen[r.status]++;
        expected_results.push_back(r);
    endfunction

    task check_result(logic signed [WORD_W-1:0] popped, logic [STATUS_W-1:0] status,
                      logic [COUNT_W-1:0] depth_now);
        stack_result_t r;
        if (expected_results.size() == 0) begin
            report($sformatf("result with no request waiting: popped %0d status %0d depth %0d",
                             popped, status, depth_now));
        end else begin
            r = expected_results.pop_front();
            if (popped !== r.popped) begin
                report($sformatf("result %0d popped_value got %0d want %0d",
                                 checked, popped, r.popped));
            end
            if (status !== r.status) begin
                report($sformatf("result %0d status got %0d want %0d",
                                 checked, status, r.status));
            end
            if (depth_now !== r.depth) begin
                report($sformatf("result %0d depth_now got %0d want %0d",
                                 checked, depth_now, r.depth));
            end
        end
        checked++;
    endtask
endclass

module tb_top;
    localparam int STACK_DEPTH = STACK_DEPTH_DEF;
    localparam int NUM_REQUESTS = 1500;
    localparam int CYCLE_LIMIT = 2500000;
    // opcodes with no operation behind them
    localparam logic [OPCODE_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_B = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n;

    osrr_in_if  req_if ();
    osrr_out_if rsp_if ();

    operand_stack_rotate_reverse #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    stack_scoreboard sb;
    int              sent = 0;
    int              send_calm = 0;
    int              recv_calm = 0;
    int              depth_goal = 8;
    int              next_fill = 300;
    longint          cycle_count = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // idle cycles before the next request or result, with runs of back-to-back traffic
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(5, 40);
        end
        return $urandom_range(0, 17);
    endfunction

    task automatic send_request(input logic [OPCODE_W-1:0] op,
                                input logic signed [WORD_W-1:0] val,
                                input logic [STEP_W-1:0] step,
                                input logic [COUNT_W-1:0] cnt);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.opcode       <= op;
        req_if.push_value   <= val;
        req_if.rotate_step  <= step;
        req_if.rotate_count <= cnt;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(op, val, step, cnt);
        if (op <= OP_REVERSE) begin
            sent++;
        end
    endtask

    task automatic wait_for_results();
        req_if.valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random();
        int unsigned              cur;
        int unsigned              roll;
        int unsigned              pick;
        int unsigned              n;
        logic [OPCODE_W-1:0]      op;
        logic signed [WORD_W-1:0] val;
        logic [STEP_W-1:0]        step;
        logic [COUNT_W-1:0]       cnt;
        cur = sb.depth;
        roll = $urandom_range(0, 99);
        val = $urandom;
        step = STEP_W'($urandom);
        cnt = COUNT_W'($urandom);
        if (sent % 40 == 0) begin
            depth_goal = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 64)
                                                      : $urandom_range(0, 24);
        end
        if (roll < 2) begin
            op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        end else if (roll < 30) begin
            op = (cur < depth_goal) ? OP_PUSH : OP_POP;
        end else if (roll < 38) begin
            op = (cur < depth_goal) ? OP_DUP : OP_POP;
        end else if (roll < 46) begin
            op = $urandom_range(0, 1) ? OP_PUSH : OP_POP;
        end else if (roll < 55) begin
            op = OP_SWAP;
        end else if (roll < 88) begin
            op = OP_ROTATE;
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                n = (cur >= 2) ? $urandom_range(2, cur) : 2;
                cnt = COUNT_W'(n);
                if (pick < 4) begin
                    step = STEP_W'($urandom_range(1, 255));
                end
            end else if (pick == 7) begin
                cnt = COUNT_W'($urandom_range(0, 1));
            end else if (pick == 8) begin
                n = $urandom_range(2, 64);
                cnt = COUNT_W'(n);
                step = STEP_W'(n * $urandom_range(0, 65535 / n));
            end
        end else begin
            op = OP_REVERSE;
        end
        if (op == OP_PUSH && $urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0: val = 32'sh8000_0000;
                1: val = 32'sh7fff_ffff;
                2: val = '0;
                default: val = -32'sd1;
            endcase
        end
        send_request(op, val, step, cnt);
    endtask

    // full stack: overflow, whole-stack rotate and reverse, then drain to underflow
    task automatic fill_and_drain();
        wait_for_results();
        while (sb.depth < STACK_DEPTH) begin
            if (sb.depth > 0 && $urandom_range(0, 3) == 0) begin
                send_request(OP_DUP, $urandom, STEP_W'($urandom), COUNT_W'($urandom));
            end else begin
                send_request(OP_PUSH, $urandom, STEP_W'($urandom), COUNT_W'($urandom));
            end
        end
        send_request(OP_PUSH, $urandom, STEP_W'($urandom), COUNT_W'($urandom));
        send_request(OP_DUP, $urandom, STEP_W'($urandom), COUNT_W'($urandom));
        send_request(OP_ROTATE, $urandom, STEP_W'($urandom_range(1, 63)), COUNT_W'(STACK_DEPTH));
        send_request(OP_ROTATE, $urandom, STEP_W'($urandom), COUNT_W'(STACK_DEPTH));
        send_request(OP_ROTATE, $urandom, STEP_W'(1), COUNT_W'($urandom_range(65, 127)));
        send_request(OP_REVERSE, $urandom, STEP_W'($urandom), COUNT_W'($urandom));
        send_request(OP_SWAP, $urandom, STEP_W'($urandom), COUNT_W'($urandom));
        while (sb.depth > 0) begin
            send_request(OP_POP, $urandom, STEP_W'($urandom), COUNT_W'($urandom));
        end
        send_request(OP_POP, $urandom, STEP_W'($urandom), COUNT_W'($urandom));
        send_request(OP_SWAP, $urandom, STEP_W'($urandom), COUNT_W'($urandom));
    endtask

    // result side
    initial begin
        int stall;
        rsp_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = draw_wait(recv_calm);
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            sb.check_result(rsp_if.popped_value, rsp_if.status, rsp_if.depth_now);
        end
    end

    // request side
    initial begin
        sb = new;
        i_rst_n             <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.opcode       <= '0;
        req_if.push_value   <= '0;
        req_if.rotate_step  <= '0;
        req_if.rotate_count <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty stack corner cases
        send_request(OP_POP, 32'sd5, 16'd0, 7'd0);
        send_request(OP_SWAP, 32'sd0, 16'd0, 7'd0);
        send_request(OP_DUP, 32'sd0, 16'd0, 7'd0);
        send_request(OP_ROTATE, 32'sd0, 16'd1, 7'd2);
        send_request(OP_ROTATE, 32'sd0, 16'hffff, 7'd0);
        send_request(OP_REVERSE, 32'sd0, 16'd0, 7'd0);
        // one entry
        send_request(OP_PUSH, 32'sh8000_0000, 16'hffff, 7'h7f);
        send_request(OP_SWAP, 32'sd0, 16'd0, 7'd0);
        send_request(OP_REVERSE, 32'sd0, 16'd0, 7'd0);
        // a few entries
        send_request(OP_PUSH, 32'sh7fff_ffff, 16'd0, 7'd0);
        send_request(OP_PUSH, -32'sd1, 16'd0, 7'd0);
        send_request(OP_DUP, 32'sd0, 16'd0, 7'd0);
        send_request(OP_SWAP, 32'sd0, 16'd0, 7'd0);
        send_request(OP_PUSH, 32'sd0, 16'd0, 7'd0);
        send_request(OP_ROTATE, 32'sd0, 16'd5, 7'd4);
        send_request(OP_ROTATE, 32'sd0, 16'd3, 7'd3);
        send_request(OP_ROTATE, 32'sd0, 16'd7, 7'd1);
        send_request(OP_ROTATE, 32'sd0, 16'hffff, 7'd127);
        send_request(OP_ROTATE, 32'sd0, 16'd1, 7'd64);
        send_request(OP_ROTATE, 32'sd0, 16'd4, 7'd5);
        send_request(OP_REVERSE, 32'sd0, 16'd0, 7'd0);
        send_request(OP_SPARE_A, 32'sd0, 16'd0, 7'd0);
        send_request(OP_SPARE_B, 32'sh7fff_ffff, 16'hffff, 7'h7f);
        send_request(OP_POP, 32'sd0, 16'd0, 7'd0);
        wait_for_results();

        while (sent < NUM_REQUESTS) begin
            if (sent >= next_fill) begin
                fill_and_drain();
                next_fill += 500;
            end
            send_random();
        end
        wait_for_results();
        repeat (300) @(posedge i_clk);

        $display("requests %0d: push %0d pop %0d swap %0d dup %0d rotate %0d reverse %0d unused %0d",
                 sb.checked, sb.op_seen[OP_PUSH], sb.op_seen[OP_POP], sb.op_seen[OP_SWAP],
                 sb.op_seen[OP_DUP], sb.op_seen[OP_ROTATE], sb.op_seen[OP_REVERSE],
                 sb.op_seen[OP_SPARE_A] + sb.op_seen[OP_SPARE_B]);
        $display("statuses: ok %0d underflow %0d overflow %0d count beyond depth %0d",
                 sb.status_seen[ST_OK], sb.status_seen[ST_UNDER], sb.status_seen[ST_OVER],
                 sb.status_seen[ST_COUNT]);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
